// ----- hw/rtl/ethertype_demux_packet_queues_core_macros.svh -----
// assertion macros for the ethertype demux checker
`ifndef ETHERTYPE_DEMUX_PACKET_QUEUES_CORE_MACROS_SVH
`define ETHERTYPE_DEMUX_PACKET_QUEUES_CORE_MACROS_SVH
// implication checked on every clock, disabled in reset
`define EDQ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("%m: check failed");
// next-cycle implication checked on every clock, disabled in reset
`define EDQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("%m: check failed");
`endif

// ----- hw/rtl/edq_pkg.sv -----
package edq_pkg;

  // operation codes
  localparam logic [2:0] OP_OPEN  = 3'd0;
  localparam logic [2:0] OP_CLOSE = 3'd1;
  localparam logic [2:0] OP_RECV  = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_XMIT  = 3'd4;
  localparam logic [2:0] OP_POLL  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_BLOCK   = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DROPPED = 3'd4;
  localparam logic [2:0] ST_NOMATCH = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam int HDR_BYTES = 14;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] protocol;
    logic [2:0]  slot;
    logic [15:0] packet_tag;
    logic [10:0] length;
    logic [15:0] buf_size;
    logic [1:0]  poll_flags;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [15:0] tag_out;
    logic [15:0] length_out;
    logic [1:0]  ready_flags;
    logic [31:0] drop_count;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ----- hw/rtl/edq_ctrl.sv -----
module edq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output edq_pkg::cmd_t  cmd
);

  edq_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      edq_pkg::S_IDLE: begin
        if (in_valid) state_next = edq_pkg::S_EXEC;
      end
      edq_pkg::S_EXEC: state_next = edq_pkg::S_DONE;
      edq_pkg::S_DONE: begin
        if (out_ready) state_next = in_valid ? edq_pkg::S_EXEC : edq_pkg::S_IDLE;
      end
      default: state_next = edq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      edq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      edq_pkg::S_EXEC: cmd.exec = 1'b1;
      edq_pkg::S_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        cmd.load  = out_ready & in_valid;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/edq_datapath.sv -----
module edq_datapath #(
  parameter int NUM_SLOTS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_BYTES   = 1514
) (
  input  logic               clk,
  input  logic               rst,
  input  edq_pkg::cmd_t      cmd,
  input  edq_pkg::in_word_t  in_word,
  output edq_pkg::out_word_t out_word
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  // each slot owns a power-of-two region so {slot, index} addresses it
  localparam int MD = NUM_SLOTS * (1 << QW);
  localparam int AW = $clog2(MD);

  logic [NUM_SLOTS-1:0] slot_valid, slot_open;
  logic [15:0] slot_ethertype [NUM_SLOTS];
  logic [31:0] slot_drops     [NUM_SLOTS];
  logic [QW-1:0] queue_head   [NUM_SLOTS];
  logic [QW-1:0] queue_tail   [NUM_SLOTS];
  logic [15:0] queue_tag [MD];
  logic [10:0] queue_len [MD];

  edq_pkg::in_word_t req;
  edq_pkg::out_word_t res;
  logic [15:0] rd_tag;
  logic [10:0] rd_len;

  // slot search for open and receive
  logic          found_hit, free_hit, recv_hit;
  logic [SW-1:0] found_idx, free_idx, recv_idx;
  always_comb begin
    found_hit = 1'b0; free_hit = 1'b0; recv_hit = 1'b0;
    found_idx = '0; free_idx = '0; recv_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_ethertype[i] == req.protocol) begin
        found_hit = 1'b1; found_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free_hit = 1'b1; free_idx = SW'(i);
      end
      if (slot_valid[i] && slot_open[i] && slot_ethertype[i] == req.protocol) begin
        recv_hit = 1'b1; recv_idx = SW'(i);
      end
    end
  end

  // addressed slot
  logic          addr_ok;
  logic [SW-1:0] as;
  always_comb begin
    as = SW'(req.slot);
    addr_ok = ({29'd0, req.slot} < NUM_SLOTS) && slot_valid[as];
  end

  logic [QW-1:0] rt_next, ah_next;
  logic [QW-1:0] rt, ahd;
  assign rt  = queue_tail[recv_idx];
  assign ahd = queue_head[as];
  assign rt_next = (32'(rt) + 1 >= QUEUE_DEPTH) ? '0 : rt + 1'b1;
  assign ah_next = (32'(ahd) + 1 >= QUEUE_DEPTH) ? '0 : ahd + 1'b1;
  logic a_empty;
  assign a_empty = (ahd == queue_tail[as]);

  logic recv_full;
  assign recv_full = (rt_next == queue_head[recv_idx]);

  // request capture and descriptor memory read
  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_word;
  end

  // read address follows the incoming word so data is ready in the execute cycle
  logic [SW-1:0] ls;
  assign ls = SW'(in_word.slot);

  logic [AW-1:0] rd_addr, wr_addr;
  assign rd_addr = AW'({ls, queue_head[ls]});
  assign wr_addr = AW'({recv_idx, rt});

  always_ff @(posedge clk) begin
    rd_tag <= queue_tag[rd_addr];
    rd_len <= queue_len[rd_addr];
    if (cmd.exec && req.operation == edq_pkg::OP_RECV && recv_hit && !recv_full) begin
      queue_tag[wr_addr] <= req.packet_tag;
      queue_len[wr_addr] <= (32'(req.length) > MAX_BYTES) ? 11'(MAX_BYTES) : req.length;
    end
  end

  logic [15:0] rd_len_x;
  assign rd_len_x = {5'd0, rd_len};

  // result word
  always_comb begin
    res = '0;
    res.status = edq_pkg::ST_INVALID;
    case (req.operation)
      edq_pkg::OP_OPEN: begin
        if (found_hit) begin
          res.slot_out = 3'(found_idx);
          res.drop_count = slot_drops[found_idx];
          res.status = slot_open[found_idx] ? edq_pkg::ST_BUSY : edq_pkg::ST_OK;
        end else if (free_hit) begin
          res.slot_out = 3'(free_idx);
          res.status = edq_pkg::ST_OK;
        end else begin
          res.status = edq_pkg::ST_FULL;
        end
      end
      edq_pkg::OP_RECV: begin
        res.status = edq_pkg::ST_NOMATCH;
        if (recv_hit) begin
          res.slot_out = 3'(recv_idx);
          if (recv_full) begin
            res.drop_count = slot_drops[recv_idx] + 32'd1;
            res.status = edq_pkg::ST_DROPPED;
          end else begin
            res.drop_count = slot_drops[recv_idx];
            res.status = edq_pkg::ST_OK;
          end
        end
      end
      edq_pkg::OP_CLOSE, edq_pkg::OP_READ, edq_pkg::OP_XMIT, edq_pkg::OP_POLL: begin
        if (addr_ok) begin
          res.slot_out = req.slot;
          res.drop_count = slot_drops[as];
          res.status = edq_pkg::ST_OK;
          case (req.operation)
            edq_pkg::OP_READ: begin
              if (a_empty) begin
                res.status = edq_pkg::ST_BLOCK;
              end else begin
                res.tag_out = rd_tag;
                res.length_out = (rd_len_x > req.buf_size) ? req.buf_size : rd_len_x;
              end
            end
            edq_pkg::OP_XMIT: begin
              if (req.buf_size < 16'(edq_pkg::HDR_BYTES) ||
                  req.protocol != slot_ethertype[as]) begin
                res.status = edq_pkg::ST_INVALID;
              end else begin
                res.length_out = req.buf_size;
              end
            end
            edq_pkg::OP_POLL: begin
              res.ready_flags = {req.poll_flags[1], req.poll_flags[0] & ~a_empty};
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // execute and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_open  <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_ethertype[i] <= '0;
        slot_drops[i] <= '0;
        queue_head[i] <= '0;
        queue_tail[i] <= '0;
      end
    end else if (cmd.exec) begin
      out_word <= res;
      case (req.operation)
        edq_pkg::OP_OPEN: begin
          if (found_hit) begin
            if (!slot_open[found_idx]) begin
              slot_open[found_idx] <= 1'b1;
              queue_head[found_idx] <= '0;
              queue_tail[found_idx] <= '0;
            end
          end else if (free_hit) begin
            slot_valid[free_idx] <= 1'b1;
            slot_open[free_idx] <= 1'b1;
            slot_ethertype[free_idx] <= req.protocol;
            slot_drops[free_idx] <= '0;
            queue_head[free_idx] <= '0;
            queue_tail[free_idx] <= '0;
          end
        end
        edq_pkg::OP_RECV: begin
          if (recv_hit) begin
            if (recv_full) begin
              slot_drops[recv_idx] <= slot_drops[recv_idx] + 32'd1;
            end else begin
              queue_tail[recv_idx] <= rt_next;
            end
          end
        end
        edq_pkg::OP_CLOSE, edq_pkg::OP_READ, edq_pkg::OP_XMIT, edq_pkg::OP_POLL: begin
          if (addr_ok) begin
            case (req.operation)
              edq_pkg::OP_CLOSE: slot_open[as] <= 1'b0;
              edq_pkg::OP_READ: begin
                if (!a_empty) queue_head[as] <= ah_next;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ethertype_demux_packet_queues_core.sv -----
// flow: an accepted word is captured, then executed, and its result word is
// registered and held valid until it is taken
// a new word is accepted while idle, or in the cycle its result is taken;
// the capture-execute pair for the slot search and descriptor memory read sets this
// reset: synchronous rst clears the slot table and queue pointers at once;
// descriptor memory is not cleared, no clearing pass
module ethertype_demux_packet_queues_core #(
  parameter int NUM_SLOTS   = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_BYTES   = 1514
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  edq_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output edq_pkg::out_word_t out_data
);

  edq_pkg::cmd_t cmd;

  edq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  edq_datapath #(
    .NUM_SLOTS(NUM_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH), .MAX_BYTES(MAX_BYTES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_data), .out_word(out_data)
  );

endmodule

// ----- hw/rtl/edq_checker.sv -----
`include "ethertype_demux_packet_queues_core_macros.svh"
module edq_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input edq_pkg::out_word_t out_data
);

  // result held while stalled
  `EDQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  // accepted word yields no result in the next cycle
  `EDQ_ASSERT_NEXT(a_no_early, clk, rst, in_valid && in_ready, !out_valid)
  // no input taken while a result stalls
  `EDQ_ASSERT_IMP(a_no_take, clk, rst, out_valid && !out_ready, !in_ready)
  // status code in range
  `EDQ_ASSERT_IMP(a_status, clk, rst, out_valid, out_data.status <= edq_pkg::ST_FULL)

endmodule

bind ethertype_demux_packet_queues_core edq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- tb/ethertype_demux_packet_queues_core_checker.sv -----
`timescale 1ns / 100ps

module ethertype_demux_packet_queues_core_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  edq_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  edq_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int SLOTS = 8;
  localparam int DEPTH = 16;
  localparam int MAXB  = 1514;

  // shadow copy of the slot table and descriptor queues
  logic        tbl_valid [SLOTS];
  logic [15:0] tbl_etype [SLOTS];
  logic        tbl_open  [SLOTS];
  logic [31:0] tbl_drops [SLOTS];
  logic [3:0]  q_head    [SLOTS];
  logic [3:0]  q_tail    [SLOTS];
  logic [15:0] q_tag     [SLOTS][DEPTH];
  logic [10:0] q_len     [SLOTS][DEPTH];

  edq_pkg::out_word_t expected_words[$];

  // apply one operation to the shadow table and return the expected result
  function automatic edq_pkg::out_word_t demux_predict(edq_pkg::in_word_t w);
    edq_pkg::out_word_t r;
    int found;
    int free_slot;
    int s;
    logic [3:0] nt;
    r = '0;
    r.status = edq_pkg::ST_INVALID;
    s = int'(w.slot);
    case (w.operation)
      edq_pkg::OP_OPEN: begin
        found = -1;
        free_slot = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (found < 0 && tbl_valid[i] && tbl_etype[i] == w.protocol) found = i;
          if (found < 0 && !tbl_valid[i] && free_slot < 0) free_slot = i;
        end
        if (found >= 0) begin
          r.slot_out = 3'(found);
          if (tbl_open[found]) r.status = edq_pkg::ST_BUSY;
          else begin
            tbl_open[found] = 1'b1;
            q_head[found] = '0;
            q_tail[found] = '0;
            r.status = edq_pkg::ST_OK;
          end
          r.drop_count = tbl_drops[found];
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_etype[free_slot] = w.protocol;
          tbl_open[free_slot] = 1'b1;
          tbl_drops[free_slot] = '0;
          q_head[free_slot] = '0;
          q_tail[free_slot] = '0;
          r.slot_out = 3'(free_slot);
          r.status = edq_pkg::ST_OK;
        end else r.status = edq_pkg::ST_FULL;
      end
      edq_pkg::OP_RECV: begin
        r.status = edq_pkg::ST_NOMATCH;
        found = -1;
        for (int i = 0; i < SLOTS; i++)
          if (found < 0 && tbl_valid[i] && tbl_open[i] && tbl_etype[i] == w.protocol)
            found = i;
        if (found >= 0) begin
          nt = q_tail[found] + 4'd1;
          r.slot_out = 3'(found);
          if (nt == q_head[found]) begin
            tbl_drops[found] = tbl_drops[found] + 32'd1;
            r.status = edq_pkg::ST_DROPPED;
          end else begin
            q_tag[found][q_tail[found]] = w.packet_tag;
            q_len[found][q_tail[found]] = (w.length > MAXB) ? 11'(MAXB) : w.length;
            q_tail[found] = nt;
            r.status = edq_pkg::ST_OK;
          end
          r.drop_count = tbl_drops[found];
        end
      end
      edq_pkg::OP_CLOSE, edq_pkg::OP_READ, edq_pkg::OP_XMIT, edq_pkg::OP_POLL: begin
        if (tbl_valid[s]) begin
          r.slot_out = w.slot;
          r.status = edq_pkg::ST_OK;
          if (w.operation == edq_pkg::OP_CLOSE) tbl_open[s] = 1'b0;
          else if (w.operation == edq_pkg::OP_READ) begin
            if (q_head[s] == q_tail[s]) r.status = edq_pkg::ST_BLOCK;
            else begin
              r.tag_out = q_tag[s][q_head[s]];
              r.length_out = (q_len[s][q_head[s]] > w.buf_size) ? w.buf_size
                                                                : 16'(q_len[s][q_head[s]]);
              q_head[s] = q_head[s] + 4'd1;
            end
          end else if (w.operation == edq_pkg::OP_XMIT) begin
            if (w.buf_size < edq_pkg::HDR_BYTES || w.protocol != tbl_etype[s])
              r.status = edq_pkg::ST_INVALID;
            else r.length_out = w.buf_size;
          end else begin
            r.ready_flags[1] = w.poll_flags[1];
            r.ready_flags[0] = w.poll_flags[0] && (q_head[s] != q_tail[s]);
          end
          r.drop_count = tbl_drops[s];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = expected_words.size();

  // predict on accepted input words, compare accepted output words
  always @(posedge clk) begin
    edq_pkg::out_word_t exp_w;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_etype[i] = '0;
        tbl_open[i] = 1'b0;
        tbl_drops[i] = '0;
        q_head[i] = '0;
        q_tail[i] = '0;
      end
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(demux_predict(in_data));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", out_data);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected st=%0d sl=%0d tag=%h len=%0d rdy=%0d drp=%0d",
                       exp_w.status, exp_w.slot_out, exp_w.tag_out, exp_w.length_out,
                       exp_w.ready_flags, exp_w.drop_count,
                       "\n          actual   st=%0d sl=%0d tag=%h len=%0d rdy=%0d drp=%0d",
                       out_data.status, out_data.slot_out, out_data.tag_out,
                       out_data.length_out, out_data.ready_flags, out_data.drop_count);
          end
        end
      end
    end
  end
endmodule

// ----- tb/ethertype_demux_packet_queues_core_test.sv -----
`timescale 1ns / 100ps

module ethertype_demux_packet_queues_core_test;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  edq_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 0;
  edq_pkg::out_word_t out_data;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;
  bit                 hold_off = 0;

  // protocols used by the random part so receives find open slots
  logic [15:0] proto_pool[10] = '{16'h0800, 16'h0806, 16'h86dd, 16'h8100, 16'h88cc,
                                  16'h0000, 16'hffff, 16'h8035, 16'h22f0, 16'h9000};

  ethertype_demux_packet_queues_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  ethertype_demux_packet_queues_core_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // send one word after a random gap; valid stays high across back-to-back words
  task automatic send_word(edq_pkg::in_word_t w, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic edq_pkg::in_word_t make_word(logic [2:0] op, logic [15:0] proto,
                                                  logic [2:0] sl);
    edq_pkg::in_word_t w;
    w.operation = op;
    w.protocol = proto;
    w.slot = sl;
    w.packet_tag = 16'($urandom);
    w.length = ($urandom_range(0, 7) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1514));
    w.buf_size = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1600));
    w.poll_flags = 2'($urandom);
    return w;
  endfunction

  // result side: random stalls, plus one long hold-off
  initial begin
    int wait_n;
    bit held_done;
    held_done = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off && !held_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        held_done = 1;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (cycle_count % 2000 < 500) wait_n = 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      out_ready <= 1'b0;
    end
  end

  initial begin
    edq_pkg::in_word_t w;
    int n;
    int pick;
    bit burst;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: invalid slots, fill the table, overflow, edges
    send_word(make_word(edq_pkg::OP_CLOSE, 16'h0, 3'd7), 0);
    send_word(make_word(edq_pkg::OP_READ, 16'h0, 3'd0), 0);
    send_word(make_word(3'd6, 16'h0, 3'd0), 0);
    send_word(make_word(3'd7, 16'hffff, 3'd7), 0);
    for (int i = 0; i < 8; i++) send_word(make_word(edq_pkg::OP_OPEN, proto_pool[i], 3'd0), 0);
    send_word(make_word(edq_pkg::OP_OPEN, proto_pool[8], 3'd0), 0);
    send_word(make_word(edq_pkg::OP_OPEN, proto_pool[0], 3'd0), 0);
    w = make_word(edq_pkg::OP_RECV, 16'hffff, 3'd0); w.length = 11'h7ff;
    w.packet_tag = 16'hffff;
    send_word(w, 0);
    w = make_word(edq_pkg::OP_READ, 16'h0, 3'd6); w.buf_size = 16'hffff; send_word(w, 0);
    w = make_word(edq_pkg::OP_XMIT, 16'hffff, 3'd6); w.buf_size = 16'd13; send_word(w, 0);
    w = make_word(edq_pkg::OP_XMIT, 16'hffff, 3'd6); w.buf_size = 16'd14; send_word(w, 0);
    w = make_word(edq_pkg::OP_XMIT, 16'h0800, 3'd6); w.buf_size = 16'd100; send_word(w, 0);
    w = make_word(edq_pkg::OP_POLL, 16'h0, 3'd0); w.poll_flags = 2'd3; send_word(w, 0);
    send_word(make_word(edq_pkg::OP_RECV, 16'h1234, 3'd0), 0);
    send_word(make_word(edq_pkg::OP_CLOSE, 16'h0, 3'd1), 0);
    send_word(make_word(edq_pkg::OP_READ, 16'h0, 3'd1), 0);
    send_word(make_word(edq_pkg::OP_OPEN, proto_pool[1], 3'd0), 0);

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    for (int i = 0; i < 12; i++)
      send_word(make_word(edq_pkg::OP_RECV, proto_pool[2], 3'd0), 1);

    // random: mostly receives and reads on known protocols
    n = 0;
    while (n < 1520) begin
      pick = $urandom_range(0, 99);
      burst = ($urandom_range(0, 7) == 0);
      if (pick < 6)
        w = make_word(edq_pkg::OP_OPEN, proto_pool[$urandom_range(0, 9)], 3'd0);
      else if (pick < 11)
        w = make_word(edq_pkg::OP_CLOSE, 16'h0, 3'($urandom));
      else if (pick < 45)
        w = make_word(edq_pkg::OP_RECV, proto_pool[$urandom_range(0, 9)], 3'd0);
      else if (pick < 75)
        w = make_word(edq_pkg::OP_READ, 16'h0, 3'($urandom));
      else if (pick < 84)
        w = make_word(edq_pkg::OP_XMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : proto_pool[$urandom_range(0, 9)], 3'($urandom));
      else if (pick < 94)
        w = make_word(edq_pkg::OP_POLL, 16'h0, 3'($urandom));
      else
        w = edq_pkg::in_word_t'({$urandom, $urandom, $urandom});
      send_word(w, burst);
      n++;
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
